// ===== hdl/dmss_pkg.sv =====
package dmss_pkg;

  localparam int unsigned STATUS_PERIOD_DEF  = 100;
  localparam int unsigned DEBOUNCE_TICKS_DEF = 3;

  localparam int unsigned MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOTE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MONITOR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MANUAL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HCAL    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HEAD    = 3'd5;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_SWITCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_LOG      = 1'b1;

  typedef enum logic [2:0] {
    RA_RESET    = 3'b001,
    RA_OFF_SEEN = 3'b010,
    RA_WAIT_OFF = 3'b100
  } rearm_e;

  typedef struct packed {
    logic              switch_raw;
    logic              torque_hit;
    logic [MODE_W-1:0] requested_mode;
    logic              head_change_req;
    logic [MODE_W-1:0] head_next_mode;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              mode_changed;
    logic              actuator_reset;
    logic              orientation_reset;
    logic              status_post;
    logic [31:0]       status_counter;
    logic              driver_switch;
    logic              log_enable_write;
    logic              log_enable_value;
  } out_item_t;

endpackage

// ===== hdl/driving_mode_safety_supervisor.sv =====
// Driving mode supervisor: one input transaction is one control tick and yields exactly one
// result transaction. The block takes a tick in every cycle in which its output register is
// empty or being drained in the same cycle, and the result sits in that register from the
// cycle after acceptance. Internally the switch is debounced over DEBOUNCE_TICKS
// ticks, the six-mode supervisor and the manual re-arm sequence advance once per tick, and a
// modulo-STATUS_PERIOD phase counter runs beside the 32-bit tick counter to flag status posts.
// Configuration writes are always accepted and should only be issued while the block is idle.
module driving_mode_safety_supervisor #(
  parameter int unsigned STATUS_PERIOD  = dmss_pkg::STATUS_PERIOD_DEF,
  parameter int unsigned DEBOUNCE_TICKS = dmss_pkg::DEBOUNCE_TICKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  dmss_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output dmss_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dmss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic                               cfg_data_i
);

  localparam int unsigned PW = (STATUS_PERIOD > 1) ? $clog2(STATUS_PERIOD) : 1;
  localparam int unsigned DW = $clog2(DEBOUNCE_TICKS + 1);
  localparam logic [PW-1:0] PHASE_LAST = PW'(STATUS_PERIOD - 1);
  localparam logic [DW-1:0] DEB_LIMIT  = DW'(DEBOUNCE_TICKS);

  logic                        ignore_q, auto_log_q;
  logic [dmss_pkg::MODE_W-1:0] mode_q, mode_d;
  dmss_pkg::rearm_e            ra_q, ra_d;
  logic [DW-1:0]               deb_q, deb_d;
  logic                        level_q, level_d;
  logic [31:0]                 tick_q, tick_d;
  logic [PW-1:0]               phase_q, phase_d;
  logic                        out_valid_q;
  dmss_pkg::out_item_t         out_q, res_d;
  logic                        in_fire;

  logic [DW-1:0]               deb_inc;
  logic                        safety, drive_req, go, is_init;
  logic                        changed, act, orient, logw;
  logic [dmss_pkg::MODE_W-1:0] req, hnext, direct;
  logic [31:0]                 tick_base;
  logic [PW-1:0]               phase_base, phase_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    req     = in_data_i.requested_mode;
    hnext   = in_data_i.head_next_mode;
    deb_inc = deb_q + DW'(1);
    level_d = level_q;
    deb_d   = '0;
    logw    = 1'b0;
    if (in_data_i.switch_raw != level_q) begin
      deb_d = deb_inc;
      if (deb_inc >= DEB_LIMIT) begin
        level_d = in_data_i.switch_raw;
        deb_d   = '0;
        logw    = auto_log_q;
      end
    end

    safety    = (!level_d && !ignore_q) || in_data_i.torque_hit;
    drive_req = (req == dmss_pkg::MODE_HEAD) || (req == dmss_pkg::MODE_REMOTE);
    direct    = (mode_q == dmss_pkg::MODE_MONITOR) ? dmss_pkg::MODE_HCAL
                                                   : dmss_pkg::MODE_MONITOR;
    mode_d  = mode_q;
    ra_d    = ra_q;
    changed = 1'b0;
    act     = 1'b0;
    orient  = 1'b0;
    go      = 1'b0;
    is_init = 1'b0;

    case (mode_q)
      dmss_pkg::MODE_REMOTE, dmss_pkg::MODE_HEAD: begin
        if (safety) begin
          mode_d  = dmss_pkg::MODE_MANUAL;
          ra_d    = dmss_pkg::RA_RESET;
          changed = 1'b1;
          act     = 1'b1;
          orient  = 1'b1;
        end else if (mode_q == dmss_pkg::MODE_REMOTE) begin
          if (req == dmss_pkg::MODE_MONITOR || req == dmss_pkg::MODE_MANUAL ||
              req == dmss_pkg::MODE_HCAL) begin
            mode_d  = req;
            ra_d    = dmss_pkg::RA_RESET;
            changed = 1'b1;
            act     = 1'b1;
          end else if (req == dmss_pkg::MODE_HEAD) begin
            mode_d  = dmss_pkg::MODE_MANUAL;
            ra_d    = dmss_pkg::RA_RESET;
            changed = 1'b1;
            act     = 1'b1;
          end
        end else begin
          if (in_data_i.head_change_req) begin
            mode_d  = (hnext <= dmss_pkg::MODE_HEAD) ? hnext : dmss_pkg::MODE_MANUAL;
            ra_d    = dmss_pkg::RA_RESET;
            changed = 1'b1;
            act     = 1'b1;
            orient  = 1'b1;
          end else if (req == dmss_pkg::MODE_MONITOR || req == dmss_pkg::MODE_HCAL ||
                       req == dmss_pkg::MODE_MANUAL) begin
            mode_d  = req;
            ra_d    = dmss_pkg::RA_RESET;
            changed = 1'b1;
            act     = 1'b1;
          end
        end
      end
      dmss_pkg::MODE_MONITOR, dmss_pkg::MODE_HCAL: begin
        if (req == dmss_pkg::MODE_MANUAL || req == direct) begin
          mode_d  = req;
          ra_d    = dmss_pkg::RA_RESET;
          changed = 1'b1;
          act     = 1'b1;
        end else if (drive_req) begin
          mode_d  = dmss_pkg::MODE_MANUAL;
          ra_d    = dmss_pkg::RA_RESET;
          changed = 1'b1;
          act     = 1'b1;
        end
      end
      dmss_pkg::MODE_MANUAL: begin
        if (ignore_q) begin
          go = drive_req;
        end else begin
          case (ra_q)
            dmss_pkg::RA_RESET: begin
              ra_d = level_d ? dmss_pkg::RA_WAIT_OFF : dmss_pkg::RA_OFF_SEEN;
            end
            dmss_pkg::RA_OFF_SEEN: begin
              go = level_d && drive_req;
            end
            dmss_pkg::RA_WAIT_OFF: begin
              if (!level_d) ra_d = dmss_pkg::RA_OFF_SEEN;
            end
            default: begin
              ra_d = dmss_pkg::RA_RESET;
            end
          endcase
        end
        if (req == dmss_pkg::MODE_MONITOR || req == dmss_pkg::MODE_HCAL) begin
          mode_d  = req;
          ra_d    = dmss_pkg::RA_RESET;
          changed = 1'b1;
          act     = 1'b1;
        end else if (go) begin
          mode_d  = req;
          ra_d    = dmss_pkg::RA_RESET;
          changed = 1'b1;
          act     = 1'b1;
          orient  = 1'b1;
        end
      end
      default: begin
        is_init = 1'b1;
        mode_d  = dmss_pkg::MODE_HEAD;
        ra_d    = dmss_pkg::RA_RESET;
        changed = 1'b1;
        act     = 1'b1;
        orient  = 1'b1;
      end
    endcase

    tick_base  = is_init ? '0 : tick_q;
    tick_d     = tick_base + 32'd1;
    phase_base = is_init ? '0 : phase_q;
    phase_inc  = (phase_base == PHASE_LAST) ? '0 : phase_base + PW'(1);
    phase_d    = (!is_init && (tick_q == '1)) ? '0 : phase_inc;

    res_d.mode              = mode_d;
    res_d.mode_changed      = changed;
    res_d.actuator_reset    = act;
    res_d.orientation_reset = orient;
    res_d.status_post       = changed || (phase_d == '0);
    res_d.status_counter    = tick_d;
    res_d.driver_switch     = level_d;
    res_d.log_enable_write  = logw;
    res_d.log_enable_value  = logw && level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_q    <= 1'b0;
      auto_log_q  <= 1'b0;
      mode_q      <= dmss_pkg::MODE_INIT;
      ra_q        <= dmss_pkg::RA_RESET;
      deb_q       <= '0;
      level_q     <= 1'b0;
      tick_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dmss_pkg::CFG_IGNORE_SWITCH: ignore_q   <= cfg_data_i;
          dmss_pkg::CFG_AUTO_LOG:      auto_log_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        mode_q  <= mode_d;
        ra_q    <= ra_d;
        deb_q   <= deb_d;
        level_q <= level_d;
        tick_q  <= tick_d;
        phase_q <= phase_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

endmodule

// ===== hdl/dmss_checker.sv =====
module dmss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dmss_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_orient_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.orientation_reset |->
      out_data_o.actuator_reset && out_data_o.mode_changed)
    else $error("orientation reset without transition");

  a_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode_changed || out_data_o.actuator_reset) |->
      out_data_o.status_post && out_data_o.mode_changed)
    else $error("transition without status post");

  a_mode_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.mode <= dmss_pkg::MODE_HEAD) &&
      (!out_data_o.log_enable_value || out_data_o.log_enable_write))
    else $error("bad mode or log value");

endmodule

bind driving_mode_safety_supervisor dmss_checker u_dmss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
